[rtl/bmee_pkg.sv]
// Package for the blocking mean error estimator: widths, constants and shared types.
// Used by the interface file, every RTL module and the checker.
`default_nettype none
package bmee_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int MAX_BLOCKS_DEFAULT  = 1024;

   localparam int SAMPLE_W     = 24;
   localparam int LEN_W        = 16;
   localparam int NUMB_W       = 11;
   localparam int INDEX_W      = 10;
   localparam int RESULT_W     = 24;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 16;

   localparam int TOTAL_W      = 48;
   localparam int MEAN_W       = 32;
   localparam int MTOT_W       = 50;
   localparam int SQ_W         = 64;
   localparam int SQTOT_W      = 80;
   localparam int CNT_W        = 17;

   localparam logic [CSR_ADDR_W-1:0] REG_BLOCK_LEN  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_NUM_BLOCKS = 1'd1;

   localparam logic [LEN_W-1:0]  BLOCK_LEN_RESET  = 16'd100;
   localparam logic [NUMB_W-1:0] NUM_BLOCKS_RESET = 11'd100;

   // One completed block handed from the front part to the back part.
   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [CNT_W-1:0]   count;
      logic               restart;
      logic               final_blk;
   } block_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  block_index;
      logic [RESULT_W-1:0] running_mean;
      logic [RESULT_W-1:0] std_error;
      logic                final_block;
   } result_type;

endpackage
`default_nettype wire

[rtl/bmee_if.sv]
// Valid/ready channel interfaces for samples and results.
// Depends on bmee_pkg.
`default_nettype none
interface bmee_req_if;
   logic                         valid;
   logic                         ready;
   logic [bmee_pkg::SAMPLE_W-1:0] sample;
   logic                         restart;
   modport source (output valid, sample, restart, input ready);
   modport sink   (input valid, sample, restart, output ready);
endinterface

interface bmee_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bmee_pkg::INDEX_W-1:0]  block_index;
   logic [bmee_pkg::RESULT_W-1:0] running_mean;
   logic [bmee_pkg::RESULT_W-1:0] std_error;
   logic                          final_block;
   modport source (output valid, block_index, running_mean, std_error, final_block,
                   input ready);
   modport sink   (input valid, block_index, running_mean, std_error, final_block,
                   output ready);
endinterface
`default_nettype wire

[rtl/bmee_front.sv]
// Front part: accumulates samples into blocks and emits one entry per completed block.
// Depends on bmee_pkg.
`default_nettype none
module bmee_front #(
   parameter int SAMPLE_BITS = bmee_pkg::SAMPLE_BITS_DEFAULT,
   parameter int MAX_BLOCKS  = bmee_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire logic [bmee_pkg::SAMPLE_W-1:0] in_sample,
   input  wire logic                          in_restart,
   input  wire logic [bmee_pkg::LEN_W-1:0]    block_len,
   input  wire logic [bmee_pkg::NUMB_W-1:0]   num_blocks,
   output      logic                          blk_valid,
   input  wire logic                          blk_ready,
   output      bmee_pkg::block_type           blk_data
);
   localparam int BD_W = $clog2(MAX_BLOCKS + 1) + 1;

   logic [bmee_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [bmee_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [BD_W-1:0]              done_ff, done_in;
   logic                         rst_pend_ff, rst_pend_in;
   logic [BD_W-1:0]              limit;
   logic [bmee_pkg::CNT_W-1:0]   len;
   logic [bmee_pkg::CNT_W-1:0]   cnt_next;
   logic [bmee_pkg::TOTAL_W-1:0] tot_next;
   logic [BD_W-1:0]              done_base;
   logic [bmee_pkg::SAMPLE_W-1:0] smp;
   logic                         fire, complete;

   // Block limit saturates to MAX_BLOCKS; a zero length acts as one.
   always_comb begin
      if (32'(num_blocks) > MAX_BLOCKS) limit = BD_W'(MAX_BLOCKS);
      else limit = BD_W'(num_blocks);
      len = (block_len == '0) ? bmee_pkg::CNT_W'(1) : bmee_pkg::CNT_W'(block_len);
      smp = in_sample & bmee_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   end

   // Every sample, not only one that completes a block, waits for a free queue slot.
   assign in_ready = blk_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      done_in     = done_ff;
      rst_pend_in = rst_pend_ff;
      done_base   = in_restart ? '0 : done_ff;
      cnt_next    = (in_restart ? '0 : count_ff) + bmee_pkg::CNT_W'(1);
      tot_next    = (in_restart ? '0 : total_ff) + bmee_pkg::TOTAL_W'(smp);
      complete    = 1'b0;
      if (fire) begin
         if (in_restart) begin
            count_in    = '0;
            total_in    = '0;
            done_in     = '0;
            rst_pend_in = 1'b1;
         end
         if (done_base < limit) begin
            if (cnt_next < len) begin
               count_in = cnt_next;
               total_in = tot_next;
            end else begin
               complete    = 1'b1;
               count_in    = '0;
               total_in    = '0;
               done_in     = done_base + BD_W'(1);
               rst_pend_in = 1'b0;
            end
         end
      end
   end

   assign blk_valid          = complete;
   assign blk_data.total     = tot_next;
   assign blk_data.count     = cnt_next;
   assign blk_data.restart   = in_restart || rst_pend_ff;
   assign blk_data.final_blk = (done_base + BD_W'(1)) == limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         total_ff    <= '0;
         done_ff     <= '0;
         rst_pend_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         total_ff    <= total_in;
         done_ff     <= done_in;
         rst_pend_ff <= rst_pend_in;
      end
   end
endmodule
`default_nettype wire

[rtl/bmee_fifo.sv]
// Short queue of completed blocks between the front and back parts.
// Depends on bmee_pkg.
`default_nettype none
module bmee_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_valid,
   output      logic                wr_ready,
   input  wire bmee_pkg::block_type wr_data,
   output      logic                rd_valid,
   input  wire logic                rd_ready,
   output      bmee_pkg::block_type rd_data
);
   bmee_pkg::block_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign wr_ready = fill_ff != 2'd2;
   assign rd_valid = fill_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = pop ? ~rp_ff : rp_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
   end
endmodule
`default_nettype wire

[rtl/bmee_back.sv]
// Back part: sequencer that folds a block mean into the running sums and computes
// the mean and error with shared bit-serial divide and square root. Depends on bmee_pkg.
`default_nettype none
module bmee_back #(
   parameter int MAX_BLOCKS = bmee_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 blk_valid,
   output      logic                 blk_ready,
   input  wire bmee_pkg::block_type  blk_data,
   output      logic                 res_valid,
   input  wire logic                 res_ready,
   output      bmee_pkg::result_type res_data
);
   localparam int NB_W = $clog2(MAX_BLOCKS + 1) + 1;
   localparam int DV_W = bmee_pkg::SQTOT_W;
   localparam int DC_W = $clog2(DV_W + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MEAN  = 4'd1;
   localparam logic [3:0] ST_SQ    = 4'd2;
   localparam logic [3:0] ST_AVG   = 4'd3;
   localparam logic [3:0] ST_AVG2  = 4'd4;
   localparam logic [3:0] ST_ASQ   = 4'd5;
   localparam logic [3:0] ST_VDIV  = 4'd6;
   localparam logic [3:0] ST_ROOT  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]                   state_ff, state_in;
   logic [bmee_pkg::MTOT_W-1:0]  mtot_ff, mtot_in;
   logic [bmee_pkg::SQTOT_W-1:0] sqtot_ff, sqtot_in;
   logic [NB_W-1:0]              n_ff, n_in;
   logic [bmee_pkg::MEAN_W-1:0]  m_ff, m_in;
   logic [bmee_pkg::MEAN_W-1:0]  avg_ff, avg_in;
   logic [bmee_pkg::SQ_W-1:0]    avg2_ff, avg2_in;
   logic                         fin_ff, fin_in;
   logic                         started_ff, started_in;
   // Shared restoring divider state.
   logic [DV_W-1:0]              quo_ff, quo_in;
   logic [DV_W-1:0]              rem_ff, rem_in;
   logic [DV_W-1:0]              dvs_ff, dvs_in;
   logic [DC_W-1:0]              dcnt_ff, dcnt_in;
   logic [DV_W:0]                rem_sh;
   // Square root state.
   logic [bmee_pkg::SQ_W-1:0]    rv_ff, rv_in, rr_ff, rr_in, rb_ff, rb_in;
   logic [bmee_pkg::SQ_W-1:0]    rsum;
   logic [bmee_pkg::SQ_W-1:0]    sq_prod;
   logic                         res_valid_ff, res_valid_in;
   bmee_pkg::result_type         res_ff, res_in;

   assign blk_ready = (state_ff == ST_IDLE) && !res_valid_ff;
   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DV_W-1]};
      sq_prod = bmee_pkg::SQ_W'(m_ff) * bmee_pkg::SQ_W'(m_ff);
      rsum    = rr_ff + rb_ff;
   end

   always_comb begin
      state_in     = state_ff;
      mtot_in      = mtot_ff;
      sqtot_in     = sqtot_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      avg_in       = avg_ff;
      avg2_in      = avg2_ff;
      fin_in       = fin_ff;
      started_in   = started_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      dcnt_in      = dcnt_ff;
      rv_in        = rv_ff;
      rr_in        = rr_ff;
      rb_in        = rb_ff;
      res_valid_in = res_valid_ff && !res_ready;
      res_in       = res_ff;

      // One divider step a cycle while a division is running.
      if (dcnt_ff != '0) begin
         quo_in  = {quo_ff[DV_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in    = DV_W'(rem_sh - {1'b0, dvs_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = rem_sh[DV_W-1:0];
         end
         dcnt_in = dcnt_ff - DC_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (blk_valid && blk_ready) begin
               if (blk_data.restart || !started_ff) begin
                  mtot_in  = '0;
                  sqtot_in = '0;
                  n_in     = NB_W'(1);
               end else begin
                  n_in = n_ff + NB_W'(1);
               end
               started_in = 1'b1;
               fin_in     = blk_data.final_blk;
               quo_in     = DV_W'(blk_data.total);
               rem_in     = '0;
               dvs_in     = DV_W'(blk_data.count);
               dcnt_in    = DC_W'(DV_W);
               state_in   = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (dcnt_ff == '0) begin
               m_in     = bmee_pkg::MEAN_W'(quo_ff);
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            mtot_in  = mtot_ff + bmee_pkg::MTOT_W'(m_ff);
            sqtot_in = sqtot_ff + bmee_pkg::SQTOT_W'(sq_prod);
            quo_in   = DV_W'(mtot_ff + bmee_pkg::MTOT_W'(m_ff));
            rem_in   = '0;
            dvs_in   = DV_W'(n_ff);
            dcnt_in  = DC_W'(DV_W);
            state_in = ST_AVG;
         end
         ST_AVG: begin
            if (dcnt_ff == '0) begin
               avg_in   = bmee_pkg::MEAN_W'(quo_ff);
               m_in     = bmee_pkg::MEAN_W'(quo_ff);
               quo_in   = sqtot_ff;
               rem_in   = '0;
               dcnt_in  = DC_W'(DV_W);
               state_in = ST_AVG2;
            end
         end
         ST_AVG2: begin
            if (dcnt_ff == '0) begin
               avg2_in  = bmee_pkg::SQ_W'(quo_ff);
               state_in = ST_ASQ;
            end
         end
         ST_ASQ: begin
            // m_ff holds avg here, so sq_prod is avg squared.
            if (n_ff == NB_W'(1)) begin
               rv_in    = '0;
               rr_in    = '0;
               rb_in    = '0;
               state_in = ST_ROOT;
            end else begin
               quo_in   = DV_W'((avg2_ff > sq_prod) ? avg2_ff - sq_prod : '0);
               rem_in   = '0;
               dvs_in   = DV_W'(n_ff - NB_W'(1));
               dcnt_in  = DC_W'(DV_W);
               state_in = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (dcnt_ff == '0) begin
               rv_in    = bmee_pkg::SQ_W'(quo_ff);
               rr_in    = '0;
               rb_in    = bmee_pkg::SQ_W'(1) << (bmee_pkg::SQ_W - 2);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // One result bit per cycle; bit reaches zero when done.
            if (rb_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               if (rv_ff >= rsum) begin
                  rv_in = rv_ff - rsum;
                  rr_in = (rr_ff >> 1) + rb_ff;
               end else begin
                  rr_in = rr_ff >> 1;
               end
               rb_in = rb_ff >> 2;
            end
         end
         ST_OUT: begin
            if (!res_valid_ff) begin
               res_in.block_index  = bmee_pkg::INDEX_W'(n_ff - NB_W'(1));
               res_in.running_mean = bmee_pkg::RESULT_W'(avg_ff);
               res_in.std_error    = bmee_pkg::RESULT_W'(rr_ff);
               res_in.final_block  = fin_ff;
               res_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mtot_ff  <= mtot_in;
      sqtot_ff <= sqtot_in;
      n_ff     <= n_in;
      m_ff     <= m_in;
      avg_ff   <= avg_in;
      avg2_ff  <= avg2_in;
      fin_ff   <= fin_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      rv_ff    <= rv_in;
      rr_ff    <= rr_in;
      rb_ff    <= rb_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         dcnt_ff      <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         dcnt_ff      <= dcnt_in;
         res_valid_ff <= res_valid_in;
      end
   end
endmodule
`default_nettype wire

[rtl/blocking_mean_error_estimator_top.sv]
// Blocking mean error estimator. Samples are accepted whenever the
// two-entry block queue has room; when the queue is full every sample waits.
// Each completed block is processed by a sequencer that runs four 80-step
// bit-serial divisions (block mean, mean of means, mean of squares, variance
// over the index) and a 32-step square root; the first block skips the
// variance division and the root. This work is overlapped with the next
// block's accumulation. The next block is taken only once the result has
// been accepted. Reset clears the sample accumulators at once, no clearing
// pass; the running sums are cleared when the first block after reset is taken.
`default_nettype none
module blocking_mean_error_estimator_top #(
   parameter int SAMPLE_BITS = bmee_pkg::SAMPLE_BITS_DEFAULT,
   parameter int MAX_BLOCKS  = bmee_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bmee_req_if.sink                             req,
   bmee_rsp_if.source                           rsp,
   input  wire logic                            csr_write_enable,
   input  wire logic [bmee_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [bmee_pkg::CSR_DATA_W-1:0] csr_write_data
);
   logic [bmee_pkg::LEN_W-1:0]  block_len_ff;
   logic [bmee_pkg::NUMB_W-1:0] num_blocks_ff;
   logic                        f_valid, f_ready, q_valid, q_ready;
   bmee_pkg::block_type         f_data, q_data;
   bmee_pkg::result_type        res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff  <= bmee_pkg::BLOCK_LEN_RESET;
         num_blocks_ff <= bmee_pkg::NUM_BLOCKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bmee_pkg::REG_BLOCK_LEN:  block_len_ff  <= csr_write_data;
            bmee_pkg::REG_NUM_BLOCKS: num_blocks_ff <= csr_write_data[bmee_pkg::NUMB_W-1:0];
            default: ;
         endcase
      end
   end

   bmee_front #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_BLOCKS(MAX_BLOCKS)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_sample(req.sample), .in_restart(req.restart),
      .block_len(block_len_ff), .num_blocks(num_blocks_ff),
      .blk_valid(f_valid), .blk_ready(f_ready), .blk_data(f_data)
   );

   bmee_fifo u_fifo (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
   );

   bmee_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
      .clock, .reset,
      .blk_valid(q_valid), .blk_ready(q_ready), .blk_data(q_data),
      .res_valid(rsp.valid), .res_ready(rsp.ready), .res_data(res)
   );

   assign rsp.block_index  = res.block_index;
   assign rsp.running_mean = res.running_mean;
   assign rsp.std_error    = res.std_error;
   assign rsp.final_block  = res.final_block;
endmodule
`default_nettype wire

[rtl/bmee_checker.sv]
// Port-level checker for the estimator, bound to the top level.
// Depends on bmee_pkg.
`default_nettype none
module bmee_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [bmee_pkg::INDEX_W-1:0]  rsp_block_index,
   input wire logic [bmee_pkg::RESULT_W-1:0] rsp_std_error
);
   // The first block always reports zero error.
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_index == '0 |-> rsp_std_error == '0)
      else $error("nonzero error on first block");

   // A stalled result stays valid and keeps its block index.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_index))
      else $error("result changed while stalled");

   // No result appears in the cycle right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result present out of reset");

   // Back-to-back results are impossible: each block needs many cycles.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("results too close together");
endmodule

bind blocking_mean_error_estimator_top bmee_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_block_index(rsp.block_index), .rsp_std_error(rsp.std_error)
);
`default_nettype wire
